/* hw/rtl/bmp565_pkg.sv */
// ----------------------------------------------------------------------------
// BMP to RGB565 package
// Shared types, constants and helpers of the BMP to RGB565 framebuffer writer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp565_pkg;

    localparam int DIM_W          = 12;
    localparam int ADDR_W         = 24;
    localparam int MAX_SCREEN_DIM = 4095;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RESET  = 12'd320;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RESET = 12'd240;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [1:0] EVENT_PIXEL       = 2'd0;
    localparam logic [1:0] EVENT_UNSUPPORTED = 2'd1;
    localparam logic [1:0] EVENT_TOO_BIG     = 2'd2;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4d42;
    localparam logic [15:0] BMP_BITS      = 16'd24;

    localparam logic [5:0] OFS_SIG0    = 6'd0;
    localparam logic [5:0] OFS_SIG1    = 6'd1;
    localparam logic [5:0] OFS_WIDTH0  = 6'd18;
    localparam logic [5:0] OFS_WIDTH1  = 6'd19;
    localparam logic [5:0] OFS_WIDTH2  = 6'd20;
    localparam logic [5:0] OFS_WIDTH3  = 6'd21;
    localparam logic [5:0] OFS_HEIGHT0 = 6'd22;
    localparam logic [5:0] OFS_HEIGHT1 = 6'd23;
    localparam logic [5:0] OFS_HEIGHT2 = 6'd24;
    localparam logic [5:0] OFS_HEIGHT3 = 6'd25;
    localparam logic [5:0] OFS_BITS0   = 6'd28;
    localparam logic [5:0] OFS_BITS1   = 6'd29;
    localparam logic [5:0] OFS_COMP0   = 6'd30;
    localparam logic [5:0] OFS_COMP1   = 6'd31;
    localparam logic [5:0] OFS_COMP2   = 6'd32;
    localparam logic [5:0] OFS_COMP3   = 6'd33;
    localparam logic [5:0] OFS_LAST    = 6'd53;

    typedef enum logic [1:0] {
        PHASE_HEADER,
        PHASE_PIXELS,
        PHASE_IDLE
    } phase_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [ADDR_W-1:0] write_address;
        logic [15:0]       pixel_value;
        logic              image_done;
    } result_t;

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
        logic [16:0] wide;
        begin
            wide = {5'd0, v};
            if (wide > 17'(MAX_SCREEN_DIM))
            begin
                return DIM_W'(MAX_SCREEN_DIM);
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bmp565_in_if.sv */
// ----------------------------------------------------------------------------
// BMP byte stream interface
// Valid/ready channel carrying one file byte and the start-of-file mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmp565_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink (input valid, input file_byte, input start_of_file, output ready);

endinterface

`default_nettype wire

/* hw/rtl/bmp565_out_if.sv */
// ----------------------------------------------------------------------------
// Framebuffer event interface
// Valid/ready channel carrying pixel writes and format events.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmp565_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [23:0] write_address;
    logic [15:0] pixel_value;
    logic        image_done;

    modport source (
        output valid, output event_kind, output write_address,
        output pixel_value, output image_done, input ready
    );
    modport sink (
        input valid, input event_kind, input write_address,
        input pixel_value, input image_done, output ready
    );

endinterface

`default_nettype wire

/* hw/rtl/bmp565_parser.sv */
// ----------------------------------------------------------------------------
// BMP parser
// Header decoder and pixel packer; produces at most one event per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp565_parser
    import bmp565_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [7:0]       file_byte,
    input  wire logic             start_of_file,
    input  wire logic [DIM_W-1:0] screen_width,
    input  wire logic [DIM_W-1:0] screen_height,
    output logic                  result_valid,
    output result_t               result
);

    phase_t            phase_reg, phase_next, phase_eff;
    logic [5:0]        count_reg, count_next, count_eff;
    logic [15:0]       sig_reg, sig_next;
    logic [15:0]       bits_reg, bits_next;
    logic              comp_nz_reg, comp_nz_next;
    logic [DIM_W-1:0]  width_low_reg, width_low_next;
    logic              width_big_reg, width_big_next;
    logic              width_neg_reg, width_neg_next;
    logic [DIM_W-1:0]  height_low_reg, height_low_next;
    logic              height_big_reg, height_big_next;
    logic              height_neg_reg, height_neg_next;
    logic [DIM_W-1:0]  column_reg, column_next;
    logic [DIM_W-1:0]  rows_left_reg, rows_left_next;
    logic [1:0]        byte_in_pixel_reg, byte_in_pixel_next;
    logic [1:0]        padding_left_reg, padding_left_next;
    logic [7:0]        blue_reg, blue_next;
    logic [7:0]        green_reg, green_next;
    logic [ADDR_W-1:0] address_reg, address_next;
    logic [DIM_W-1:0]  start_row_reg, start_row_next;
    logic [DIM_W-1:0]  start_col_reg, start_col_next;
    logic [DIM_W-1:0]  pitch_reg, pitch_next;
    logic              pending_reg, pending_next;

    logic [DIM_W-1:0]  sw_lim, sh_lim, half_y;
    logic [ADDR_W-1:0] start_product;
    logic              header_end, fmt_bad, too_big, empty_image, start_ok;
    logic              pixel_fire, row_end, pixel_last;
    logic [DIM_W-1:0]  col_plus, rows_minus;

    assign sw_lim    = limit_dim(screen_width);
    assign sh_lim    = limit_dim(screen_height);
    assign phase_eff = start_of_file ? PHASE_HEADER : phase_reg;
    assign count_eff = start_of_file ? 6'd0 : count_reg;

    assign header_end  = take && (phase_eff == PHASE_HEADER) && (count_eff == OFS_LAST);
    assign fmt_bad     = (sig_reg != BMP_SIGNATURE) || (bits_reg != BMP_BITS) ||
                         comp_nz_reg || width_neg_reg || height_neg_reg;
    assign too_big     = width_big_reg || height_big_reg ||
                         (width_low_reg > sw_lim) || (height_low_reg > sh_lim);
    assign empty_image = (width_low_reg == '0) || (height_low_reg == '0);
    assign start_ok    = !fmt_bad && !too_big && !empty_image;

    assign half_y        = (sh_lim - height_low_reg) >> 1;
    assign start_product = ADDR_W'(start_row_reg) * ADDR_W'(pitch_reg);

    assign pixel_fire = take && (phase_eff == PHASE_PIXELS) &&
                        (padding_left_reg == 2'd0) && (byte_in_pixel_reg == 2'd2);
    assign col_plus   = column_reg + DIM_W'(1);
    assign rows_minus = rows_left_reg - DIM_W'(1);
    assign row_end    = col_plus >= width_low_reg;
    assign pixel_last = pixel_fire && row_end && (rows_minus == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = phase_eff;
            case (phase_eff)
                PHASE_HEADER:
                begin
                    if (count_eff == OFS_LAST)
                    begin
                        phase_next = start_ok ? PHASE_PIXELS : PHASE_IDLE;
                    end
                end
                PHASE_PIXELS:
                begin
                    if (pixel_last)
                    begin
                        phase_next = PHASE_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next         = count_reg;
        sig_next           = sig_reg;
        bits_next          = bits_reg;
        comp_nz_next       = comp_nz_reg;
        width_low_next     = width_low_reg;
        width_big_next     = width_big_reg;
        width_neg_next     = width_neg_reg;
        height_low_next    = height_low_reg;
        height_big_next    = height_big_reg;
        height_neg_next    = height_neg_reg;
        column_next        = column_reg;
        rows_left_next     = rows_left_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        padding_left_next  = padding_left_reg;
        blue_next          = blue_reg;
        green_next         = green_reg;
        address_next       = address_reg;
        start_row_next     = start_row_reg;
        start_col_next     = start_col_reg;
        pitch_next         = pitch_reg;
        pending_next       = 1'b0;

        // The start address is formed in the cycle after the header ends.
        if (pending_reg)
        begin
            address_next = start_product + ADDR_W'(start_col_reg);
        end

        if (take)
        begin
            case (phase_eff)
                PHASE_HEADER:
                begin
                    count_next = count_eff + 6'd1;
                    case (count_eff)
                        OFS_SIG0:    sig_next[7:0]  = file_byte;
                        OFS_SIG1:    sig_next[15:8] = file_byte;
                        OFS_WIDTH0:  width_low_next[7:0] = file_byte;
                        OFS_WIDTH1:
                        begin
                            width_low_next[11:8] = file_byte[3:0];
                            width_big_next       = |file_byte[7:4];
                        end
                        OFS_WIDTH2:  width_big_next = width_big_reg | (|file_byte);
                        OFS_WIDTH3:
                        begin
                            width_big_next = width_big_reg | (|file_byte[6:0]);
                            width_neg_next = file_byte[7];
                        end
                        OFS_HEIGHT0: height_low_next[7:0] = file_byte;
                        OFS_HEIGHT1:
                        begin
                            height_low_next[11:8] = file_byte[3:0];
                            height_big_next       = |file_byte[7:4];
                        end
                        OFS_HEIGHT2: height_big_next = height_big_reg | (|file_byte);
                        OFS_HEIGHT3:
                        begin
                            height_big_next = height_big_reg | (|file_byte[6:0]);
                            height_neg_next = file_byte[7];
                        end
                        OFS_BITS0:   bits_next[7:0]  = file_byte;
                        OFS_BITS1:   bits_next[15:8] = file_byte;
                        OFS_COMP0:   comp_nz_next = |file_byte;
                        OFS_COMP1, OFS_COMP2, OFS_COMP3:
                        begin
                            comp_nz_next = comp_nz_reg | (|file_byte);
                        end
                        default:
                        begin
                            count_next = count_eff + 6'd1;
                        end
                    endcase
                    if (header_end && start_ok)
                    begin
                        start_row_next     = half_y + height_low_reg - DIM_W'(1);
                        start_col_next     = (sw_lim - width_low_reg) >> 1;
                        pitch_next         = sw_lim;
                        pending_next       = 1'b1;
                        rows_left_next     = height_low_reg;
                        column_next        = '0;
                        byte_in_pixel_next = 2'd0;
                        padding_left_next  = 2'd0;
                    end
                end
                PHASE_PIXELS:
                begin
                    if (padding_left_reg != 2'd0)
                    begin
                        padding_left_next = padding_left_reg - 2'd1;
                    end
                    else if (byte_in_pixel_reg == 2'd0)
                    begin
                        blue_next          = file_byte;
                        byte_in_pixel_next = 2'd1;
                    end
                    else if (byte_in_pixel_reg == 2'd1)
                    begin
                        green_next         = file_byte;
                        byte_in_pixel_next = 2'd2;
                    end
                    else
                    begin
                        byte_in_pixel_next = 2'd0;
                        column_next        = col_plus;
                        if (row_end)
                        begin
                            rows_left_next = rows_minus;
                            if (rows_minus != '0)
                            begin
                                column_next       = '0;
                                padding_left_next = width_low_reg[1:0];
                                address_next      = address_reg + ADDR_W'(1)
                                                    - ADDR_W'(width_low_reg)
                                                    - ADDR_W'(sw_lim);
                            end
                        end
                        else
                        begin
                            address_next = address_reg + ADDR_W'(1);
                        end
                    end
                end
                default:
                begin
                    pending_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        result_valid         = 1'b0;
        result.event_kind    = EVENT_PIXEL;
        result.write_address = '0;
        result.pixel_value   = '0;
        result.image_done    = 1'b0;
        if (header_end && fmt_bad)
        begin
            result_valid      = 1'b1;
            result.event_kind = EVENT_UNSUPPORTED;
        end
        else if (header_end && too_big)
        begin
            result_valid      = 1'b1;
            result.event_kind = EVENT_TOO_BIG;
        end
        else if (pixel_fire)
        begin
            result_valid         = 1'b1;
            result.write_address = address_reg;
            result.pixel_value   = {file_byte[7:3], green_reg[7:2], blue_reg[7:3]};
            result.image_done    = pixel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PHASE_HEADER;
            count_reg         <= '0;
            byte_in_pixel_reg <= '0;
            padding_left_reg  <= '0;
            pending_reg       <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            count_reg         <= count_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            padding_left_reg  <= padding_left_next;
            pending_reg       <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg        <= sig_next;
        bits_reg       <= bits_next;
        comp_nz_reg    <= comp_nz_next;
        width_low_reg  <= width_low_next;
        width_big_reg  <= width_big_next;
        width_neg_reg  <= width_neg_next;
        height_low_reg <= height_low_next;
        height_big_reg <= height_big_next;
        height_neg_reg <= height_neg_next;
        column_reg     <= column_next;
        rows_left_reg  <= rows_left_next;
        blue_reg       <= blue_next;
        green_reg      <= green_next;
        address_reg    <= address_next;
        start_row_reg  <= start_row_next;
        start_col_reg  <= start_col_next;
        pitch_reg      <= pitch_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (phase_reg == PHASE_PIXELS))
        else $error("start address pending outside the pixel phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_PIXELS) |-> (rows_left_reg != '0))
        else $error("pixel phase with no rows left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_PIXELS) |-> (column_reg < width_low_reg))
        else $error("column count ran past the image width");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PHASE_PIXELS) && (padding_left_reg != 2'd0))
            |-> (byte_in_pixel_reg == 2'd0))
        else $error("row padding in the middle of a pixel");

endmodule

`default_nettype wire

/* hw/rtl/bmp24_to_rgb565_framebuffer_writer.sv */
// ----------------------------------------------------------------------------
// BMP24 to RGB565 framebuffer writer
// Parses a 24-bit BMP byte stream and emits centered RGB565 pixel writes.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle, with no gaps of its own, and
// every event appears in the output register in the cycle after the transfer of
// the byte that causes it. A byte is taken only when the output register is
// empty or its event leaves in the same cycle, so a stalled event output holds
// off the byte stream. The start address of the image needs one
// 12 by 12 bit multiply, which runs in the cycle after the last header byte
// while the first pixel's bytes arrive.
`default_nettype none

module bmp24_to_rgb565_framebuffer_writer
    import bmp565_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bmp565_in_if.sink             byte_stream,
    bmp565_out_if.source          event_stream,
    input  wire logic             cfg_write_enable,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_write_data
);

    logic [DIM_W-1:0] screen_width_reg, screen_width_next;
    logic [DIM_W-1:0] screen_height_reg, screen_height_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;
    logic             take;
    logic             result_valid;
    result_t          result;

    assign byte_stream.ready = !out_valid_reg || event_stream.ready;
    assign take              = byte_stream.valid && byte_stream.ready;

    bmp565_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .file_byte     (byte_stream.file_byte),
        .start_of_file (byte_stream.start_of_file),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .result_valid  (result_valid),
        .result        (result)
    );

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_next  = cfg_write_data;
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_write_data;
                default:           screen_width_next  = screen_width_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && event_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = result_valid;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign event_stream.valid         = out_valid_reg;
    assign event_stream.event_kind    = out_data_reg.event_kind;
    assign event_stream.write_address = out_data_reg.write_address;
    assign event_stream.pixel_value   = out_data_reg.pixel_value;
    assign event_stream.image_done    = out_data_reg.image_done;

endmodule

`default_nettype wire

/* verif/bmp565_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP to RGB565 frame checker
// Watches the byte, event and register channels of the framebuffer writer,
// keeps its own copy of the parser state to predict every event, and compares
// each event transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bmp565_frame_checker
    import bmp565_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bmp565_in_if             byte_mon,
    bmp565_out_if            event_mon,
    input  logic             cfg_write_enable,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_write_data,
    output int               fail_count,
    output int               pending_events
);

    logic [DIM_W-1:0]  screen_w;
    logic [DIM_W-1:0]  screen_h;
    phase_t            phase;
    logic [5:0]        hdr_count;
    logic [15:0]       signature;
    logic [31:0]       img_w;
    logic [31:0]       img_h;
    logic [15:0]       bit_count;
    logic [31:0]       compression;
    logic [11:0]       column;
    logic [11:0]       rows_left;
    logic [1:0]        byte_slot;
    logic [1:0]        pad_left;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [ADDR_W-1:0] next_addr;
    result_t           predicted_events[$];
    result_t           oldest;

    function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v);
        begin
            if (32'(v) > 32'(MAX_SCREEN_DIM))
            begin
                return 32'(MAX_SCREEN_DIM);
            end
            return 32'(v);
        end
    endfunction

    task automatic clear_parse();
        begin
            phase       = PHASE_HEADER;
            hdr_count   = '0;
            signature   = '0;
            img_w       = '0;
            img_h       = '0;
            bit_count   = '0;
            compression = '0;
            column      = '0;
            rows_left   = '0;
            byte_slot   = '0;
            pad_left    = '0;
            blue        = '0;
            green       = '0;
            next_addr   = '0;
        end
    endtask

    task automatic push_event(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                              input logic [15:0] pixel, input logic last);
        result_t ev;
        begin
            ev.event_kind    = kind;
            ev.write_address = addr;
            ev.pixel_value   = pixel;
            ev.image_done    = last;
            predicted_events.push_back(ev);
        end
    endtask

    task automatic parse_file_byte(input logic [7:0] value, input logic sof);
        int                n;
        logic [31:0]       sw;
        logic [31:0]       sh;
        logic [31:0]       x0;
        logic [31:0]       y0;
        logic [31:0]       sum;
        logic [15:0]       pixel;
        logic [ADDR_W-1:0] addr;
        logic              last;
        begin
            if (sof)
            begin
                clear_parse();
            end
            if (phase == PHASE_HEADER)
            begin
                n = int'(hdr_count);
                if (n <= int'(OFS_SIG1))
                begin
                    signature[8*n +: 8] = value;
                end
                else if (n >= int'(OFS_WIDTH0) && n <= int'(OFS_WIDTH3))
                begin
                    img_w[8*(n - int'(OFS_WIDTH0)) +: 8] = value;
                end
                else if (n >= int'(OFS_HEIGHT0) && n <= int'(OFS_HEIGHT3))
                begin
                    img_h[8*(n - int'(OFS_HEIGHT0)) +: 8] = value;
                end
                else if (n >= int'(OFS_BITS0) && n <= int'(OFS_BITS1))
                begin
                    bit_count[8*(n - int'(OFS_BITS0)) +: 8] = value;
                end
                else if (n >= int'(OFS_COMP0) && n <= int'(OFS_COMP3))
                begin
                    compression[8*(n - int'(OFS_COMP0)) +: 8] = value;
                end
                hdr_count = hdr_count + 6'd1;
                if (n == int'(OFS_LAST))
                begin
                    phase = PHASE_IDLE;
                    sw = clamp_dim(screen_w);
                    sh = clamp_dim(screen_h);
                    if (signature != BMP_SIGNATURE || bit_count != BMP_BITS ||
                        compression != 32'd0 || img_h[31] || img_w[31])
                    begin
                        push_event(EVENT_UNSUPPORTED, '0, '0, 1'b0);
                    end
                    else if (img_w > sw || img_h > sh)
                    begin
                        push_event(EVENT_TOO_BIG, '0, '0, 1'b0);
                    end
                    else if (img_w != 32'd0 && img_h != 32'd0)
                    begin
                        x0        = (sw - img_w) / 32'd2;
                        y0        = (sh - img_h) / 32'd2;
                        sum       = (y0 + img_h - 32'd1) * sw + x0;
                        next_addr = sum[ADDR_W-1:0];
                        rows_left = img_h[11:0];
                        column    = '0;
                        byte_slot = '0;
                        pad_left  = '0;
                        phase     = PHASE_PIXELS;
                    end
                end
            end
            else if (phase == PHASE_PIXELS)
            begin
                if (pad_left != 2'd0)
                begin
                    pad_left = pad_left - 2'd1;
                end
                else if (byte_slot == 2'd0)
                begin
                    blue      = value;
                    byte_slot = 2'd1;
                end
                else if (byte_slot == 2'd1)
                begin
                    green     = value;
                    byte_slot = 2'd2;
                end
                else
                begin
                    byte_slot = 2'd0;
                    pixel     = {value[7:3], green[7:2], blue[7:3]};
                    addr      = next_addr;
                    last      = 1'b0;
                    column    = column + 12'd1;
                    if (32'(column) >= img_w)
                    begin
                        rows_left = rows_left - 12'd1;
                        if (rows_left == 12'd0)
                        begin
                            last  = 1'b1;
                            phase = PHASE_IDLE;
                        end
                        else
                        begin
                            column    = '0;
                            pad_left  = img_w[1:0];
                            sum       = 32'(next_addr) + 32'd1 - img_w - clamp_dim(screen_w);
                            next_addr = sum[ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        next_addr = next_addr + 24'd1;
                    end
                    push_event(EVENT_PIXEL, addr, pixel, last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w = SCREEN_WIDTH_RESET;
            screen_h = SCREEN_HEIGHT_RESET;
            clear_parse();
            predicted_events.delete();
            fail_count     = 0;
            pending_events = 0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                begin
                    screen_w = cfg_write_data;
                end
                else
                begin
                    screen_h = cfg_write_data;
                end
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                parse_file_byte(byte_mon.file_byte, byte_mon.start_of_file);
            end
            if (event_mon.valid && event_mon.ready)
            begin
                if (predicted_events.size() == 0)
                begin
                    $error("unexpected event transfer: kind %0d address %0d pixel %h done %0d",
                           event_mon.event_kind, event_mon.write_address,
                           event_mon.pixel_value, event_mon.image_done);
                    fail_count++;
                end
                else
                begin
                    oldest = predicted_events.pop_front();
                    if (event_mon.event_kind !== oldest.event_kind)
                    begin
                        $error("event_kind: expected %0d, actual %0d",
                               oldest.event_kind, event_mon.event_kind);
                        fail_count++;
                    end
                    if (event_mon.write_address !== oldest.write_address)
                    begin
                        $error("write_address: expected %0d, actual %0d",
                               oldest.write_address, event_mon.write_address);
                        fail_count++;
                    end
                    if (event_mon.pixel_value !== oldest.pixel_value)
                    begin
                        $error("pixel_value: expected %h, actual %h",
                               oldest.pixel_value, event_mon.pixel_value);
                        fail_count++;
                    end
                    if (event_mon.image_done !== oldest.image_done)
                    begin
                        $error("image_done: expected %0d, actual %0d",
                               oldest.image_done, event_mon.image_done);
                        fail_count++;
                    end
                end
            end
            pending_events = predicted_events.size();
        end
    end

endmodule

/* verif/bmp24_to_rgb565_framebuffer_writer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP24 to RGB565 framebuffer writer testbench
// Streams directed and random bitmap files through the writer under several
// screen sizes, with random gaps on the byte side and random stalls on the
// event side, and reports the verdict of the frame checker.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_framebuffer_writer_test;
    import bmp565_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 300;
    localparam int RANDOM_PHASES  = 6;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write_enable = 1'b0;
    logic             cfg_index = CFG_SCREEN_WIDTH;
    logic [DIM_W-1:0] cfg_write_data = '0;

    bmp565_in_if  byte_stream ();
    bmp565_out_if event_stream ();

    int               fail_count;
    int               pending_events;
    logic [7:0]       file_q[$];
    int               bytes_sent = 0;
    bit               no_gaps = 1'b0;
    int               out_wait = 0;
    logic             event_taken = 1'b0;
    int               idle_cycles = 0;
    logic [DIM_W-1:0] scr_w = SCREEN_WIDTH_RESET;
    logic [DIM_W-1:0] scr_h = SCREEN_HEIGHT_RESET;

    bmp24_to_rgb565_framebuffer_writer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_stream      (byte_stream),
        .event_stream     (event_stream),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data)
    );

    bmp565_frame_checker frame_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_mon         (byte_stream),
        .event_mon        (event_stream),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data),
        .fail_count       (fail_count),
        .pending_events   (pending_events)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        event_taken <= event_stream.valid && event_stream.ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (event_taken)
            begin
                out_wait = no_gaps ? 0 : $urandom_range(0, 10);
            end
            if (out_wait > 0)
            begin
                event_stream.ready <= 1'b0;
                out_wait--;
            end
            else
            begin
                event_stream.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_stream.valid && byte_stream.ready) ||
                (event_stream.valid && event_stream.ready) || cfg_write_enable)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic sof);
        int gap;
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            repeat (gap)
            begin
                @(negedge clk);
                byte_stream.valid <= 1'b0;
            end
            @(negedge clk);
            byte_stream.valid         <= 1'b1;
            byte_stream.file_byte     <= value;
            byte_stream.start_of_file <= sof;
            @(posedge clk);
            while (!(byte_stream.valid && byte_stream.ready))
            begin
                @(posedge clk);
            end
            bytes_sent++;
        end
    endtask

    task automatic send_noise(input int count);
        begin
            repeat (count)
            begin
                send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic settle();
        begin
            @(negedge clk);
            byte_stream.valid <= 1'b0;
            while (pending_events != 0)
            begin
                @(negedge clk);
            end
            repeat (6)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic set_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        begin
            settle();
            cfg_write_enable <= 1'b1;
            cfg_index        <= CFG_SCREEN_WIDTH;
            cfg_write_data   <= w;
            @(negedge clk);
            cfg_index        <= CFG_SCREEN_HEIGHT;
            cfg_write_data   <= h;
            @(negedge clk);
            cfg_write_enable <= 1'b0;
            scr_w = w;
            scr_h = h;
        end
    endtask

    task automatic put_word(input logic [31:0] value, input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                file_q.push_back(value[8*i +: 8]);
            end
        end
    endtask

    task automatic build_header(input logic [15:0] sig, input logic [31:0] w,
                                input logic [31:0] h, input logic [15:0] bits,
                                input logic [31:0] comp);
        begin
            file_q.delete();
            put_word(32'(sig), 2);
            repeat (4)
            begin
                put_word($urandom, 4);
            end
            put_word(w, 4);
            put_word(h, 4);
            put_word($urandom, 2);
            put_word(32'(bits), 2);
            put_word(comp, 4);
            repeat (20)
            begin
                file_q.push_back(8'($urandom));
            end
        end
    endtask

    task automatic add_pixels(input int w, input int h, input int fill);
        begin
            for (int r = 0; r < h; r++)
            begin
                for (int c = 0; c < 3 * w; c++)
                begin
                    file_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
                end
                repeat (w % 4)
                begin
                    file_q.push_back(8'($urandom));
                end
            end
        end
    endtask

    task automatic send_file(input logic first_sof);
        begin
            foreach (file_q[i])
            begin
                send_byte(file_q[i], (i == 0) ? first_sof : 1'b0);
            end
        end
    endtask

    task automatic good_file(input int w, input int h, input int fill);
        begin
            build_header(BMP_SIGNATURE, 32'(w), 32'(h), BMP_BITS, 32'd0);
            add_pixels(w, h, fill);
            send_file(1'b1);
        end
    endtask

    task automatic random_file();
        int          pick;
        int          cap_w;
        int          cap_h;
        int          cut;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] sig;
        logic [15:0] bits;
        logic [31:0] comp;
        begin
            cap_w   = (int'(scr_w) < 9) ? int'(scr_w) : 9;
            cap_h   = (int'(scr_h) < 5) ? int'(scr_h) : 5;
            w       = (cap_w == 0) ? 32'd1 : 32'($urandom_range(1, cap_w));
            h       = (cap_h == 0) ? 32'd1 : 32'($urandom_range(1, cap_h));
            sig     = BMP_SIGNATURE;
            bits    = BMP_BITS;
            comp    = 32'd0;
            pick    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (pick < 70)
            begin
                good_file(int'(w), int'(h), -1);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_noise($urandom_range(1, 6));
                end
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    w = 32'(scr_w) + 32'($urandom_range(1, 3));
                end
                else
                begin
                    h = 32'(scr_h) + 32'($urandom_range(1, 3));
                end
                build_header(sig, w, h, bits, comp);
                send_file(1'b1);
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        sig = 16'($urandom);
                        if (sig == BMP_SIGNATURE)
                        begin
                            sig = sig ^ 16'h0100;
                        end
                    end
                    1:
                    begin
                        bits = 16'($urandom);
                        if (bits == BMP_BITS)
                        begin
                            bits = bits ^ 16'h0001;
                        end
                    end
                    2:
                    begin
                        comp = $urandom | (32'd1 << $urandom_range(0, 31));
                    end
                    3:
                    begin
                        h = h | 32'h8000_0000 | $urandom;
                    end
                    default:
                    begin
                        w = w | 32'h8000_0000 | $urandom;
                    end
                endcase
                build_header(sig, w, h, bits, comp);
                send_file(1'b1);
                send_noise($urandom_range(0, 4));
            end
            else if (pick < 95)
            begin
                build_header(sig, w, h, bits, comp);
                add_pixels(int'(w), int'(h), -1);
                cut    = $urandom_range(1, file_q.size() - 1);
                file_q = file_q[0:cut-1];
                send_file(1'b1);
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    w = 32'd0;
                end
                else
                begin
                    h = 32'd0;
                end
                build_header(sig, w, h, bits, comp);
                send_file(1'b1);
                send_noise($urandom_range(1, 8));
            end
        end
    endtask

    initial
    begin
        int target;

        byte_stream.valid         = 1'b0;
        byte_stream.file_byte     = 8'd0;
        byte_stream.start_of_file = 1'b0;
        event_stream.ready        = 1'b0;
        repeat (8)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // The first file comes without a start mark, and trailing bytes follow it.
        build_header(BMP_SIGNATURE, 32'd3, 32'd2, BMP_BITS, 32'd0);
        add_pixels(3, 2, -1);
        send_file(1'b0);
        send_noise(5);

        good_file(1, 1, 255);
        good_file(1, 1, 0);
        for (int w = 4; w <= 7; w++)
        begin
            good_file(w, 2, -1);
        end

        build_header(16'h4d43, 32'd2, 32'd2, BMP_BITS, 32'd0);
        send_file(1'b1);
        build_header(BMP_SIGNATURE, 32'd2, 32'd2, 16'd16, 32'd0);
        send_file(1'b1);
        build_header(BMP_SIGNATURE, 32'd2, 32'd2, BMP_BITS, 32'd1);
        send_file(1'b1);
        build_header(BMP_SIGNATURE, 32'd2, 32'hffff_fffe, BMP_BITS, 32'd0);
        send_file(1'b1);
        build_header(BMP_SIGNATURE, 32'h8000_0000, 32'd2, BMP_BITS, 32'd0);
        send_file(1'b1);
        send_noise(3);

        build_header(BMP_SIGNATURE, 32'd321, 32'd1, BMP_BITS, 32'd0);
        send_file(1'b1);
        build_header(BMP_SIGNATURE, 32'd1, 32'd241, BMP_BITS, 32'd0);
        send_file(1'b1);

        build_header(BMP_SIGNATURE, 32'd0, 32'd3, BMP_BITS, 32'd0);
        send_file(1'b1);
        send_noise(6);
        build_header(BMP_SIGNATURE, 32'd3, 32'd0, BMP_BITS, 32'd0);
        send_file(1'b1);

        // A restart in the middle of a header, then in the middle of the pixels.
        build_header(BMP_SIGNATURE, 32'd2, 32'd2, BMP_BITS, 32'd0);
        file_q = file_q[0:19];
        send_file(1'b1);
        good_file(2, 1, -1);
        build_header(BMP_SIGNATURE, 32'd4, 32'd3, BMP_BITS, 32'd0);
        add_pixels(4, 3, -1);
        file_q = file_q[0:70];
        send_file(1'b1);
        good_file(1, 2, -1);

        set_screen(12'd0, 12'd0);
        good_file(1, 1, -1);
        build_header(BMP_SIGNATURE, 32'd0, 32'd0, BMP_BITS, 32'd0);
        send_file(1'b1);

        set_screen(12'd4095, 12'd4095);
        good_file(2, 2, -1);
        build_header(BMP_SIGNATURE, 32'd4096, 32'd1, BMP_BITS, 32'd0);
        send_file(1'b1);

        set_screen(12'd1, 12'd1);
        good_file(1, 1, -1);
        build_header(BMP_SIGNATURE, 32'd2, 32'd1, BMP_BITS, 32'd0);
        send_file(1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_screen(12'($urandom_range(1, 16)), 12'($urandom_range(1, 8)));
                1: set_screen(12'd4095, 12'd4095);
                2: set_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
                3: set_screen(12'($urandom_range(1, 3)), 12'($urandom_range(1, 3)));
                4: set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
                default: set_screen(12'($urandom_range(1, 40)), 12'($urandom_range(1, 20)));
            endcase
            target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
            while (bytes_sent < target)
            begin
                random_file();
            end
        end

        settle();
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bmp565_pkg.sv
hw/rtl/bmp565_in_if.sv
hw/rtl/bmp565_out_if.sv
hw/rtl/bmp565_parser.sv
hw/rtl/bmp24_to_rgb565_framebuffer_writer.sv
verif/bmp565_frame_checker.sv
verif/bmp24_to_rgb565_framebuffer_writer_test.sv
